// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent assertions used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AST_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/skset_pkg.sv =====
// ----------------------------------------------------------------------------
// skset_pkg
// Types and codes shared by the sorted key set cells and top level.
// ----------------------------------------------------------------------------
package skset_pkg;

  localparam int KEY_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes. The unused code behaves as a lookup.
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    key_t              key;
  } skset_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } skset_out_t;

  // Shift commands broadcast to every cell.
  typedef struct packed {
    logic ins_en;  // open a slot at the insert point, shifting right
    logic rem_en;  // close the slot at the match, shifting left
  } skset_ctl_t;

endpackage

// ===== hw/rtl/skset_cell.sv =====
// ----------------------------------------------------------------------------
// skset_cell
// One slot of the sorted key row: compares its key with the broadcast key
// and shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module skset_cell (
  input  logic                clk,
  input  skset_pkg::skset_ctl_t ctl,
  input  logic                slot_valid,
  input  skset_pkg::key_t     probe_key,
  input  skset_pkg::key_t     left_key,
  input  logic                left_less,
  input  skset_pkg::key_t     right_key,
  output skset_pkg::key_t     key_q,
  output logic                less,
  output logic                eq
);
  import skset_pkg::*;

  key_t key_r;
  key_t key_nxt;

  assign less  = slot_valid && (key_r < probe_key);
  assign eq    = slot_valid && (key_r == probe_key);
  assign key_q = key_r;

  // Cells below the insert or match point keep their keys. The first cell at
  // or above it takes the new key on insert; later cells take their left
  // neighbor. On remove every cell from the match upward takes its right one.
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins_en && !less) begin
      key_nxt = left_less ? probe_key : left_key;
    end else if (ctl.rem_en && !less) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== hw/rtl/sorted_key_set_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_set_unit
// Ordered set of distinct signed 32-bit keys held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   An operation beat (in_item: func and key) is taken at a rising edge where
//   start is high and busy is low. func selects insert, remove or lookup; the
//   unused code acts as a lookup.
//   Every cell compares its key against the operation key in parallel during
//   the cycle after the beat is taken. Because the row is sorted, each cell
//   knows from its own and its left neighbor's compare whether to hold, load
//   the new key, or shift, so the whole row updates together in that cycle.
//   The result beat (status, found, count) appears on out_result for exactly
//   one cycle with out_strobe high, starting in the cycle after the compare
//   cycle. busy is high for the single compare cycle, so a new operation is
//   accepted only once busy has dropped, not while the last one is still in
//   its compare-and-shift pass across the cell row.
//   The receiver cannot stall: the result beat is simply presented once.
//   Reset (rst_n low, synchronous) empties the set and drops busy and the
//   strobe. Cell contents are not cleared; slots above the key count are
//   masked off by the count itself.
// ----------------------------------------------------------------------------
module sorted_key_set_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  skset_pkg::skset_in_t   in_item,
  output logic                   out_strobe,
  output skset_pkg::skset_out_t  out_result
);
  import skset_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // Operation held for the compare-and-shift cycle.
  logic              busy_r;
  logic [FUNC_W-1:0] func_r;
  key_t              key_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic       out_strobe_r;
  skset_out_t out_result_r;
  skset_out_t out_result_nxt;

  key_t              cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_less;
  logic [CAPACITY-1:0] cell_eq;
  logic [CAPACITY-1:0] slot_valid;

  skset_ctl_t ctl;
  logic       present;
  logic       full;
  logic       is_insert;
  logic       is_remove;
  logic [STAT_W-1:0] status;
  logic [CW+COUNT_W-1:0] count_ext;

  // The cell row. Neighbor ports at the ends are tied so that the first cell
  // sees the new key on its left and the last cell sees itself on its right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t left_key;
    logic left_less;
    key_t right_key;

    assign slot_valid[i] = count_r > CW'(i);

    if (i == 0) begin : g_first
      assign left_key  = key_r;
      assign left_less = 1'b1;
    end else begin : g_mid
      assign left_key  = cell_key[i-1];
      assign left_less = cell_less[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    skset_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot_valid (slot_valid[i]),
      .probe_key  (key_r),
      .left_key   (left_key),
      .left_less  (left_less),
      .right_key  (right_key),
      .key_q      (cell_key[i]),
      .less       (cell_less[i]),
      .eq         (cell_eq[i])
    );
  end

  // Keys are distinct, so at most one valid cell can match.
  assign present   = |cell_eq;
  assign full      = count_r == CW'(CAPACITY);
  assign is_insert = func_r == FN_INSERT;
  assign is_remove = func_r == FN_REMOVE;

  assign ctl.ins_en = busy_r && is_insert && !present && !full;
  assign ctl.rem_en = busy_r && is_remove && present;

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // A duplicate is reported ahead of a full table.
  always_comb begin
    if (is_insert) begin
      if (present) begin
        status = ST_DUP;
      end else if (full) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end else begin
      status = present ? ST_OK : ST_NOTFOUND;
    end
  end

  // The count field keeps only its low bits when the capacity is large.
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    out_result_nxt.status = status;
    out_result_nxt.found  = present;
    out_result_nxt.count  = count_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= start && !busy_r;
      count_r      <= count_nxt;
      out_strobe_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      func_r <= in_item.func;
      key_r  <= in_item.key;
    end
    if (busy_r) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  // Assertions.
  `include "assert_macros.svh"

  `AST_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY),
            "key count above capacity")
  `AST_NEXT(a_accept_busy, clk, rst_n, start && !busy_r, busy_r && !out_strobe_r,
            "accepted operation did not enter the compare cycle")
  `AST_NEXT(a_busy_result, clk, rst_n, busy_r, out_strobe_r && !busy_r,
            "compare cycle did not produce exactly one result")
  `AST_NEXT(a_insert_count, clk, rst_n, ctl.ins_en, count_r == $past(count_r) + CW'(1),
            "insert did not raise the key count")
  `AST_SAME(a_single_match, clk, rst_n, busy_r, $onehot0(cell_eq),
            "more than one cell matches the key")

endmodule
